// ===== design/ptw_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the four-level page table walker
// no dependencies; imported by every module of the walker

package ptw_pkg;

  localparam int unsigned TABLE_WORDS_DEF   = 16384;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned LEVELS            = 4;

  localparam int unsigned VA_W          = 64;
  localparam int unsigned PA_W          = 52;
  localparam int unsigned ENTRY_W       = 64;
  localparam int unsigned WORD_INDEX_W  = 14;
  localparam int unsigned PAGE_OFF_BITS = 12;
  localparam int unsigned IDX_W         = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned LVL_W         = $clog2(LEVELS);
  localparam int unsigned FRAME_W       = PA_W - PAGE_OFF_BITS;
  localparam int unsigned VA_USED_W     = PAGE_OFF_BITS + IDX_W * LEVELS;
  localparam int unsigned PRESENT_BIT   = 0;

  localparam logic [PA_W-1:0] SPAN_MIN = PA_W'(64'h0000_0000_FFFF_FFFF);

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_WALK  = 1'b1
  } ptw_op_e;

  typedef enum logic [1:0] {
    CFG_ROOT        = 2'd0,
    CFG_DMAP_OFFSET = 2'd1,
    CFG_MEM_TOTAL   = 2'd2
  } ptw_cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } ptw_state_e;

  typedef struct packed {
    ptw_op_e                 op;
    logic [VA_W-1:0]         vaddr;
    logic [WORD_INDEX_W-1:0] table_word_index;
    logic [ENTRY_W-1:0]      table_word_data;
  } ptw_req_t;

  typedef struct packed {
    logic [PA_W-1:0] paddr;
    logic            fault;
    logic            direct_mapped;
  } ptw_rsp_t;

  typedef struct packed {
    logic [PA_W-1:0] root_table_addr;
    logic [VA_W-1:0] direct_map_offset;
    logic [PA_W-1:0] mem_total;
  } ptw_cfg_t;

  localparam ptw_rsp_t FAULT_RSP = '{paddr: '0, fault: 1'b1, direct_mapped: 1'b0};

  // table index used at a given walk level, top level first
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_USED_W-1:0] va,
                                                   input logic [LVL_W-1:0] lvl);
    return va[PAGE_OFF_BITS + IDX_W * (LEVELS - 1 - lvl) +: IDX_W];
  endfunction

endpackage

// ===== design/ptw_table_mem.sv =====
`timescale 1ns / 1ps
// table word store: one write port, one read port with registered read data
// depends on ptw_pkg

module ptw_table_mem import ptw_pkg::*; #(
  parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(TABLE_WORDS)-1:0] waddr,
  input  logic [ENTRY_W-1:0]             wdata,
  input  logic                           re,
  input  logic [$clog2(TABLE_WORDS)-1:0] raddr,
  output logic [ENTRY_W-1:0]             rdata
);

  logic [ENTRY_W-1:0] mem [TABLE_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ptw_walker.sv =====
`timescale 1ns / 1ps
// walk sequencer: direct map check, four dependent table reads, output register
// depends on ptw_pkg; drives the ports of ptw_table_mem

module ptw_walker import ptw_pkg::*; #(
  parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ptw_cfg_t                       cfg,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  ptw_req_t                       req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output ptw_rsp_t                       rsp,
  output logic                           mem_we,
  output logic [$clog2(TABLE_WORDS)-1:0] mem_waddr,
  output logic [ENTRY_W-1:0]             mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(TABLE_WORDS)-1:0] mem_raddr,
  input  logic [ENTRY_W-1:0]             mem_rdata
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);

  function automatic logic [AW-1:0] word_addr(input logic [FRAME_W-1:0] frame,
                                              input logic [IDX_W-1:0] idx);
    logic [FRAME_W+IDX_W-1:0] full;
    full = {frame, idx};
    return full[AW-1:0];
  endfunction

  ptw_state_e             state, state_next;
  logic [LVL_W-1:0]       level, level_next;
  logic [VA_USED_W-1:0]   vaddr, vaddr_next;
  ptw_rsp_t               pend, pend_next;
  ptw_rsp_t               rsp_next;
  logic                   rsp_valid_next;

  logic                   slot_free;
  logic                   root_zero;
  logic                   in_window;
  logic [PA_W-1:0]        span;
  logic [VA_W:0]          upper_sum;
  logic [VA_W-1:0]        upper;
  logic [VA_W-1:0]        diff;
  logic [63:0]            widx;
  logic                   fin;
  ptw_rsp_t               fin_rsp;

  // direct map window, saturating at the top of the address space
  assign span      = (cfg.mem_total > SPAN_MIN) ? cfg.mem_total : SPAN_MIN;
  assign upper_sum = {1'b0, cfg.direct_map_offset} + (VA_W + 1)'(span);
  assign upper     = upper_sum[VA_W] ? '1 : upper_sum[VA_W-1:0];
  assign in_window = (req.vaddr >= cfg.direct_map_offset) && (req.vaddr <= upper);
  assign diff      = req.vaddr - cfg.direct_map_offset;
  assign root_zero = (cfg.root_table_addr == '0);
  assign slot_free = !rsp_valid || rsp_ready;
  assign widx      = 64'(req.table_word_index);

  always_comb begin
    state_next     = state;
    level_next     = level;
    vaddr_next     = vaddr;
    pend_next      = pend;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    req_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = widx[AW-1:0];
    mem_wdata      = req.table_word_data;
    mem_re         = 1'b0;
    mem_raddr      = word_addr(cfg.root_table_addr[PA_W-1:PAGE_OFF_BITS],
                               level_index(req.vaddr[VA_USED_W-1:0], '0));
    fin            = 1'b0;
    fin_rsp        = FAULT_RSP;

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.op == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            vaddr_next = req.vaddr[VA_USED_W-1:0];
            level_next = '0;
            if (root_zero) begin
              fin     = 1'b1;
              fin_rsp = FAULT_RSP;
            end else if (in_window) begin
              fin     = 1'b1;
              fin_rsp = '{paddr: diff[PA_W-1:0], fault: 1'b0, direct_mapped: 1'b1};
            end else begin
              mem_re     = 1'b1;
              state_next = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        if (!mem_rdata[PRESENT_BIT]) begin
          fin     = 1'b1;
          fin_rsp = FAULT_RSP;
        end else if (level == LVL_W'(LEVELS - 1)) begin
          fin     = 1'b1;
          fin_rsp = '{paddr: {mem_rdata[PA_W-1:PAGE_OFF_BITS], vaddr[PAGE_OFF_BITS-1:0]},
                      fault: 1'b0, direct_mapped: 1'b0};
        end else begin
          mem_re     = 1'b1;
          level_next = LVL_W'(level + 1'b1);
          mem_raddr  = word_addr(mem_rdata[PA_W-1:PAGE_OFF_BITS],
                                 level_index(vaddr, LVL_W'(level + 1'b1)));
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          rsp_next       = pend;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // finished translation goes straight to the output register when it is free
    if (fin) begin
      pend_next = fin_rsp;
      if (slot_free) begin
        rsp_next       = fin_rsp;
        rsp_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end else begin
        state_next = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      level     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      level     <= level_next;
      rsp_valid <= rsp_valid_next;
    end
    vaddr <= vaddr_next;
    pend  <= pend_next;
    rsp   <= rsp_next;
  end

  // table writes only happen between walks, never beside a read
  assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("table write and read issued together");

  assert property (@(posedge clk) disable iff (rst) mem_re |=> state == ST_WALK)
    else $error("table read issued without a walk step to consume it");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && $past(state) == ST_WALK) |-> level == LVL_W'($past(level) + 1'b1))
    else $error("walk level did not advance by one");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.fault) |-> (rsp.paddr == '0 && !rsp.direct_mapped))
    else $error("fault transaction carries an address");

endmodule

// ===== design/four_level_page_table_walker_unit.sv =====
`timescale 1ns / 1ps
// four-level page table walker: request channel, response channel, config port.
// A request with op write loads one 64-bit table word into the local store and
// gives no response. A request with op walk translates vaddr and gives one
// response: paddr, fault, direct_mapped.
// A translation that faults on a zero root or falls in the direct map window
// is loaded into the output register on acceptance if that register is free,
// else it waits in the pending register; a table walk makes four dependent
// reads of the table store, one per cycle with registered read data. The next
// request is taken once the sequencer is back in idle: a walk ends before the
// next one starts; other requests run one per cycle unless the output stalls.
// The output register holds a finished response while the receiver stalls;
// the sequencer still returns to idle, and only a second finished response
// waits inside until the register frees.
// Reset clears the sequencer and the config registers (all zero). The table
// store is not cleared: a walk must only read words that were written.
// Config writes are taken every cycle and must only come while no transaction
// is in flight.

module four_level_page_table_walker_unit import ptw_pkg::*; #(
  parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  ptw_req_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output ptw_rsp_t    rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);

  ptw_cfg_t            cfg;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROOT:        cfg.root_table_addr   <= cfg_data[PA_W-1:0];
        CFG_DMAP_OFFSET: cfg.direct_map_offset <= cfg_data;
        CFG_MEM_TOTAL:   cfg.mem_total         <= cfg_data[PA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ptw_table_mem #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_table_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptw_walker #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== bench/ptw_translation_checker.sv =====
`timescale 1ns / 1ps
// translation checker for the four-level page table walker: watches the request,
// response and config channels, keeps its own table image and config, predicts
// each translation and compares it. Depends on ptw_pkg.

module ptw_translation_checker import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  ptw_req_t    req,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  ptw_rsp_t    rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [PA_W-1:0]    root_q;
  logic [VA_W-1:0]    dmap_q;
  logic [PA_W-1:0]    mem_q;
  logic [ENTRY_W-1:0] tbl_words [TABLE_WORDS_DEF];
  ptw_rsp_t           xlat_q [$];

  function automatic ptw_rsp_t walk_result(input logic [VA_W-1:0] va);
    ptw_rsp_t                r;
    logic [VA_W-1:0]         span;
    logic [VA_W-1:0]         upper;
    logic [ENTRY_W-1:0]      ent;
    logic [PA_W-1:0]         base;
    logic [WORD_INDEX_W-1:0] w;
    int                      lvl;
    r = FAULT_RSP;
    if (root_q == '0) return r;
    span = (mem_q > SPAN_MIN) ? VA_W'(mem_q) : VA_W'(SPAN_MIN);
    upper = dmap_q + span;
    if (upper < dmap_q) upper = '1;
    if (va >= dmap_q && va <= upper) begin
      r.paddr = PA_W'(va - dmap_q);
      r.fault = 1'b0;
      r.direct_mapped = 1'b1;
      return r;
    end
    base = {root_q[PA_W-1:PAGE_OFF_BITS], {PAGE_OFF_BITS{1'b0}}};
    ent = '0;
    for (lvl = 0; lvl < LEVELS; lvl++) begin
      w = WORD_INDEX_W'((base >> 3) + va[PAGE_OFF_BITS + IDX_W * (LEVELS - 1 - lvl) +: IDX_W]);
      ent = tbl_words[w];
      if (!ent[PRESENT_BIT]) return r;
      base = {ent[PA_W-1:PAGE_OFF_BITS], {PAGE_OFF_BITS{1'b0}}};
    end
    r.paddr = {ent[PA_W-1:PAGE_OFF_BITS], va[PAGE_OFF_BITS-1:0]};
    r.fault = 1'b0;
    r.direct_mapped = 1'b0;
    return r;
  endfunction

  function automatic int field_err(input string name, input logic [63:0] want,
                                   input logic [63:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    ptw_rsp_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      root_q = '0;
      dmap_q = '0;
      mem_q = '0;
      xlat_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (xlat_q.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
          errs++;
        end else begin
          want = xlat_q.pop_front();
          errs += field_err("paddr", 64'(want.paddr), 64'(rsp.paddr));
          errs += field_err("fault", 64'(want.fault), 64'(rsp.fault));
          errs += field_err("direct_mapped", 64'(want.direct_mapped), 64'(rsp.direct_mapped));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROOT:        root_q = cfg_data[PA_W-1:0];
          CFG_DMAP_OFFSET: dmap_q = cfg_data;
          CFG_MEM_TOTAL:   mem_q = cfg_data[PA_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        if (req.op == OP_WRITE) tbl_words[req.table_word_index] = req.table_word_data;
        else xlat_q.push_back(walk_result(req.vaddr));
      end
    end
    fail_count <= fail_count + errs;
    pending <= xlat_q.size();
  end

endmodule

// ===== bench/tb_four_level_page_table_walker_unit.sv =====
`timescale 1ns / 1ps
// testbench top for four_level_page_table_walker_unit: clock, reset, stimulus,
// idle and stall patterns, timeout and verdict. Depends on ptw_pkg, the walker
// RTL and ptw_translation_checker, which does all prediction and comparison.

module tb_four_level_page_table_walker_unit;
  import ptw_pkg::*;

  localparam int ITEM_TARGET = 1500;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  ptw_req_t    req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  ptw_rsp_t    rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  int          items_sent;
  int          req_idle_pct;
  int          rsp_stall_pct;
  int          cycle_count;
  int          hold_left;
  bit          hold_go;
  bit          hold_done;

  logic [PA_W-1:0]    cur_root;
  logic [VA_W-1:0]    cur_off;
  logic [PA_W-1:0]    cur_mem;
  logic [ENTRY_W-1:0] tbl_image [TABLE_WORDS_DEF];
  bit                 tbl_loaded [TABLE_WORDS_DEF];
  logic [VA_W-1:0]    va_pool [$];

  four_level_page_table_walker_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ptw_translation_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_four_level_page_table_walker_unit: FAIL");
    $finish;
  end

  // response side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      rsp_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  function automatic logic [VA_W-1:0] window_top();
    logic [VA_W-1:0] span;
    logic [VA_W-1:0] upper;
    span = (cur_mem > SPAN_MIN) ? VA_W'(cur_mem) : VA_W'(SPAN_MIN);
    upper = cur_off + span;
    if (upper < cur_off) upper = '1;
    return upper;
  endfunction

  function automatic logic [VA_W-1:0] pick_vaddr();
    logic [VA_W-1:0] va;
    logic [VA_W-1:0] upper;
    int              sel;
    upper = window_top();
    sel = $urandom_range(99);
    va = {$urandom, $urandom};
    if (sel < 35 && va_pool.size() != 0) begin
      va = va_pool[$urandom_range(va_pool.size() - 1)];
      va[PAGE_OFF_BITS-1:0] = PAGE_OFF_BITS'($urandom);
      if ($urandom_range(1) == 1) va[VA_W-1:VA_USED_W] = (VA_W - VA_USED_W)'($urandom);
    end else if (sel < 50) begin
      va = cur_off + (va % (upper - cur_off + 1));
    end else if (sel < 60) begin
      case ($urandom_range(3))
        0: va = cur_off;
        1: va = upper;
        2: va = cur_off - 1;
        default: va = upper + 1;
      endcase
    end
    return va;
  endfunction

  // valid stays high from one transaction to the next unless a gap is taken
  task automatic send_req(input ptw_req_t r);
    if ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < req_idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_write(input logic [WORD_INDEX_W-1:0] w, input logic [ENTRY_W-1:0] d);
    ptw_req_t r;
    r.op = OP_WRITE;
    r.vaddr = {$urandom, $urandom};
    r.table_word_index = w;
    r.table_word_data = d;
    tbl_image[w] = d;
    tbl_loaded[w] = 1'b1;
    send_req(r);
  endtask

  task automatic send_walk(input logic [VA_W-1:0] va);
    ptw_req_t r;
    r.op = OP_WALK;
    r.vaddr = va;
    r.table_word_index = WORD_INDEX_W'($urandom);
    r.table_word_data = {$urandom, $urandom};
    send_req(r);
  endtask

  // loads any missing entry on the path first, so no walk touches an unloaded word
  // passes repeat until one loads nothing, since a write may alias an earlier level
  task automatic walk_addr(input logic [VA_W-1:0] va);
    logic [PA_W-1:0]         base;
    logic [WORD_INDEX_W-1:0] w;
    logic [ENTRY_W-1:0]      ent;
    int                      lvl;
    bit                      stop;
    bit                      wrote;
    bit                      first_pass;
    if (cur_root != '0 && !(va >= cur_off && va <= window_top())) begin
      first_pass = 1'b1;
      do begin
        wrote = 1'b0;
        base = {cur_root[PA_W-1:PAGE_OFF_BITS], {PAGE_OFF_BITS{1'b0}}};
        stop = 1'b0;
        for (lvl = 0; lvl < LEVELS && !stop; lvl++) begin
          w = WORD_INDEX_W'((base >> 3) +
                            va[PAGE_OFF_BITS + IDX_W * (LEVELS - 1 - lvl) +: IDX_W]);
          if (!tbl_loaded[w] || (first_pass && $urandom_range(7) == 0)) begin
            ent = {$urandom, $urandom};
            ent[PRESENT_BIT] = ($urandom_range(15) != 0);
            send_write(w, ent);
            wrote = 1'b1;
          end
          ent = tbl_image[w];
          if (!ent[PRESENT_BIT]) stop = 1'b1;
          else base = {ent[PA_W-1:PAGE_OFF_BITS], {PAGE_OFF_BITS{1'b0}}};
        end
        first_pass = 1'b0;
      end while (wrote);
    end
    send_walk(va);
    va_pool.push_back(va);
    if (va_pool.size() > 64) void'(va_pool.pop_front());
  endtask

  task automatic cfg_put(input ptw_cfg_reg_e idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [PA_W-1:0] root, input logic [VA_W-1:0] off,
                            input logic [PA_W-1:0] mem);
    cfg_put(CFG_ROOT, {12'($urandom), root});
    cfg_put(CFG_DMAP_OFFSET, off);
    cfg_put(CFG_MEM_TOTAL, {12'($urandom), mem});
    cfg_valid <= 1'b0;
    cur_root = root;
    cur_off = off;
    cur_mem = mem;
  endtask

  // wait until every translation has come back and a write could have landed
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int              ph;
    int              phase_end;
    logic [PA_W-1:0] root;
    logic [VA_W-1:0] off;
    logic [PA_W-1:0] mem;
    cur_root = '0;
    cur_off = '0;
    cur_mem = '0;
    req_idle_pct = 0;
    rsp_stall_pct <= 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero root after reset, also inside the reset window
    send_walk(64'h0);
    send_walk('1);
    send_write('0, '1);
    send_write('1, 64'h0);
    drain();

    set_config({40'hFF_FFFF_FFFF, 12'hABC}, 64'hFFFF_8000_0000_0000, '0);
    walk_addr(64'hFFFF_8000_0000_0000);
    walk_addr(64'hFFFF_8000_FFFF_FFFF);
    walk_addr(64'hFFFF_8001_0000_0000);
    walk_addr(64'h0000_7FFF_FFFF_F123);
    // same walk, other sign-extension bits
    walk_addr(64'hABCD_7FFF_FFFF_F123);
    drain();

    // window end saturates at the top of the address space
    set_config(52'h1, 64'hFFFF_FFFF_FFFF_F000, 52'hF_FFFF_FFFF_FFFF);
    walk_addr('1);
    walk_addr(64'hFFFF_FFFF_FFFF_EFFF);
    drain();

    set_config('0, 64'h1000, 52'h1_0000_0000);
    walk_addr(64'h2000);

    for (ph = 0; items_sent < ITEM_TARGET; ph++) begin
      drain();
      case ($urandom_range(4))
        0: root = '0;
        1: root = '1;
        2: root = PA_W'($urandom_range(4095));
        default: root = PA_W'({$urandom, $urandom});
      endcase
      case ($urandom_range(4))
        0: off = '0;
        1: off = '1;
        2: off = {17'h1_FFFF, 47'({$urandom, $urandom})};
        default: off = {$urandom, $urandom};
      endcase
      case ($urandom_range(3))
        0: mem = '0;
        1: mem = '1;
        2: mem = PA_W'($urandom);
        default: mem = PA_W'({$urandom, $urandom});
      endcase
      set_config(root, off, mem);
      case (ph % 4)
        0: begin
          req_idle_pct = 0;
          rsp_stall_pct <= 0;
        end
        1: begin
          req_idle_pct = 74;
          rsp_stall_pct <= 0;
        end
        2: begin
          req_idle_pct = 0;
          rsp_stall_pct <= 74;
        end
        default: begin
          req_idle_pct = 13;
          rsp_stall_pct <= 13;
        end
      endcase
      if (ph == 4) hold_go <= 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(4) == 0) send_write(WORD_INDEX_W'($urandom), {$urandom, $urandom});
        else walk_addr(pick_vaddr());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb_four_level_page_table_walker_unit: PASS");
    end else begin
      $display("tb_four_level_page_table_walker_unit: FAIL");
    end
    $finish;
  end

endmodule
